// ===== hdl/aging_transaction_result_cache_defines.svh =====
// Assertion macros shared by the cache RTL.
`ifndef AGING_TRANSACTION_RESULT_CACHE_DEFINES_SVH
`define AGING_TRANSACTION_RESULT_CACHE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define ATRC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ATRC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/atrc_pkg.sv =====
// Package: commands, record kinds, register indexes, states and widths of the cache.
package atrc_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int KEY_WIDTH_DEF = 64;

    localparam int ID_W    = 64;
    localparam int DATA_W  = 64;
    localparam int TIME_W  = 48;
    localparam int CNTR_W  = 32;
    localparam int CFG_W   = 32;
    localparam int CAP_W   = 5;
    localparam int S_TDATA_W = 304;
    localparam int M_TDATA_W = 464;

    localparam logic [CAP_W-1:0]  MAX_ENTRIES_RST = 5'd16;
    localparam logic [CNTR_W-1:0] RETENTION_RST   = 32'd60000;

    typedef enum logic [1:0] {
        CMD_STORE = 2'd0,
        CMD_FIND  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_EXPIRED  = 3'd0,
        KIND_CAPACITY = 3'd1,
        KIND_STORED   = 3'd2,
        KIND_HIT      = 3'd3,
        KIND_MISS     = 3'd4,
        KIND_MISMATCH = 3'd5,
        KIND_CLEARED  = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        REG_MAX_ENTRIES = 2'd0,
        REG_RETENTION   = 2'd1,
        REG_REPORT      = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COUNT,
        ST_PURGE,
        ST_EVICT,
        ST_FINAL
    } state_t;

endpackage

// ===== hdl/aging_transaction_result_cache.sv =====
// Top level: aging transaction result cache built on a chain of entry cells.
// A find rotates the chain once to count aged entries, then passes again to drop them and
// look up the id, then emits its result. A store updates a matching entry in that pass, or
// evicts oldest entries for capacity and appends the new one; a clear goes straight to its final record.
// Next request is taken in the cycle after the final record; records wait for a free result register.
// aresetn (sync, low) empties the table, zeroes counters and restores register defaults.
module aging_transaction_result_cache #(
    parameter int DEPTH     = atrc_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = atrc_pkg::KEY_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // config write port
    input  logic                            cfg_wr_en,
    input  logic [1:0]                      cfg_addr,
    input  logic [atrc_pkg::CFG_W-1:0]      cfg_wr_data,
    // request channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // tdata: tx_id_hi, tx_id_lo, key, payload, now_ms
    input  logic [atrc_pkg::S_TDATA_W-1:0]  s_tdata,
    // tuser: cmd
    input  logic [1:0]                      s_tuser,
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // tdata: out_tx_id_hi, out_tx_id_lo, out_key, out_payload, stored_at,
    //        hit_count, miss_count, mismatch_count, expired_count, capacity_count
    output logic [atrc_pkg::M_TDATA_W-1:0]  m_tdata,
    // tuser: kind
    output logic [2:0]                      m_tuser,
    output logic                            m_tlast
);

    import atrc_pkg::*;

    `include "aging_transaction_result_cache_defines.svh"

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W + 1 : CAP_W + 1;
    // entry layout: hi, lo, key, payload, time from the low bits up
    localparam int O_LO  = ID_W;
    localparam int O_KEY = 2 * ID_W;
    localparam int O_PAY = O_KEY + KEY_WIDTH;
    localparam int O_TIM = O_PAY + DATA_W;
    localparam int EW    = O_TIM + TIME_W;

    // config registers
    logic [CAP_W-1:0]  max_entries_reg;
    logic [CNTR_W-1:0] retention_reg;
    logic              report_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_entries_reg <= MAX_ENTRIES_RST;
            retention_reg   <= RETENTION_RST;
            report_reg      <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_MAX_ENTRIES: begin
                    max_entries_reg <= (cfg_wr_data[CAP_W-1:0] == '0) ?
                                       CAP_W'(1) : cfg_wr_data[CAP_W-1:0];
                end
                REG_RETENTION: retention_reg <= cfg_wr_data;
                REG_REPORT:    report_reg    <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // effective capacity, clipped to the chain length
    logic [CMP_W-1:0] cap_w;
    assign cap_w = (CMP_W'(max_entries_reg) > CMP_W'(DEPTH)) ?
                   CMP_W'(DEPTH) : CMP_W'(max_entries_reg);

    // control state
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  rot_reg, rot_next;
    logic [CNT_W-1:0]  gone_reg, gone_next;
    logic              found_reg, found_next;
    logic              mkey_reg, mkey_next;
    logic [DATA_W-1:0] mpay_reg, mpay_next;
    logic [CNTR_W-1:0] hit_reg, hit_next, miss_reg, miss_next, mism_reg, mism_next;
    logic [CNTR_W-1:0] exp_reg, exp_next, capc_reg, capc_next;

    // latched request
    cmd_t                 cmd_reg;
    logic [ID_W-1:0]      hi_reg, lo_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [DATA_W-1:0]    pay_reg;
    logic [TIME_W-1:0]    now_reg;

    // result register
    logic              out_valid_reg;
    kind_t             out_kind_reg;
    logic              out_last_reg;
    logic [ID_W-1:0]   out_hi_reg, out_lo_reg;
    logic [DATA_W-1:0] out_key_reg, out_pay_reg;
    logic [TIME_W-1:0] out_time_reg;
    logic [CNTR_W-1:0] out_hit_reg, out_miss_reg, out_mism_reg, out_exp_reg, out_capc_reg;

    // chain
    logic [EW-1:0]    cell_q [DEPTH];
    logic             shift_en, load_any;
    logic [CNT_W-1:0] load_idx;
    logic [EW-1:0]    load_data;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [EW-1:0] right_d;
            if (gi < DEPTH - 1) begin : g_mid
                assign right_d = cell_q[gi+1];
            end else begin : g_end
                assign right_d = '0;
            end
            atrc_cell #(.W(EW)) u_cell (
                .aclk       (aclk),
                .shift_en   (shift_en),
                .load_en    (load_any && (load_idx == CNT_W'(gi))),
                .load_data  (load_data),
                .right_data (right_d),
                .data_out   (cell_q[gi])
            );
        end
    endgenerate

    // head fields
    logic [ID_W-1:0]      h_hi, h_lo;
    logic [KEY_WIDTH-1:0] h_key;
    logic [DATA_W-1:0]    h_pay;
    logic [TIME_W-1:0]    h_time;
    logic                 head_old, out_free, emit;
    logic [EW-1:0]        new_entry, upd_entry;

    assign h_hi   = cell_q[0][O_LO-1:0];
    assign h_lo   = cell_q[0][O_KEY-1:O_LO];
    assign h_key  = cell_q[0][O_PAY-1:O_KEY];
    assign h_pay  = cell_q[0][O_TIM-1:O_PAY];
    assign h_time = cell_q[0][EW-1:O_TIM];

    // age check: time running backward never expires
    assign head_old = (now_reg >= h_time) &&
                      ((now_reg - h_time) > TIME_W'(retention_reg));
    assign out_free  = !out_valid_reg || m_tready;
    assign new_entry = {now_reg, pay_reg, key_reg, lo_reg, hi_reg};
    assign upd_entry = {h_time, pay_reg, key_reg, h_lo, h_hi};
    assign s_tready  = (state_reg == ST_IDLE);

    // emitted record
    kind_t             e_kind;
    logic              e_last;
    logic [ID_W-1:0]   e_hi, e_lo;
    logic [DATA_W-1:0] e_key, e_pay;
    logic [TIME_W-1:0] e_time;

    // sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rot_next   = rot_reg;
        gone_next  = gone_reg;
        found_next = found_reg;
        mkey_next  = mkey_reg;
        mpay_next  = mpay_reg;
        hit_next   = hit_reg;
        miss_next  = miss_reg;
        mism_next  = mism_reg;
        exp_next   = exp_reg;
        capc_next  = capc_reg;
        shift_en   = 1'b0;
        load_any   = 1'b0;
        load_idx   = cnt_reg - CNT_W'(1);
        load_data  = cell_q[0];
        emit       = 1'b0;
        e_kind     = KIND_STORED;
        e_last     = 1'b0;
        e_hi       = h_hi;
        e_lo       = h_lo;
        e_key      = DATA_W'(h_key);
        e_pay      = h_pay;
        e_time     = h_time;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    rot_next   = cnt_reg;
                    gone_next  = '0;
                    found_next = 1'b0;
                    case (cmd_t'(s_tuser))
                        CMD_STORE, CMD_FIND: state_next = ST_COUNT;
                        CMD_CLEAR:           state_next = ST_FINAL;
                        default: ;
                    endcase
                end
            end
            ST_COUNT: begin
                if (rot_reg == '0) begin
                    exp_next   = exp_reg + CNTR_W'(gone_reg);
                    rot_next   = cnt_reg;
                    state_next = ST_PURGE;
                end else begin
                    // rotate head to tail, count aged entries
                    shift_en  = 1'b1;
                    load_any  = 1'b1;
                    gone_next = gone_reg + CNT_W'(head_old);
                    rot_next  = rot_reg - CNT_W'(1);
                end
            end
            ST_PURGE: begin
                if (rot_reg == '0) begin
                    state_next = (cmd_reg == CMD_STORE && !found_reg) ? ST_EVICT : ST_FINAL;
                end else if (head_old) begin
                    if (!report_reg || out_free) begin
                        shift_en = 1'b1;
                        cnt_next = cnt_reg - CNT_W'(1);
                        rot_next = rot_reg - CNT_W'(1);
                        emit     = report_reg;
                        e_kind   = KIND_EXPIRED;
                    end
                end else begin
                    shift_en = 1'b1;
                    load_any = 1'b1;
                    rot_next = rot_reg - CNT_W'(1);
                    if (!found_reg && h_hi == hi_reg && h_lo == lo_reg) begin
                        found_next = 1'b1;
                        mkey_next  = (h_key == key_reg);
                        mpay_next  = h_pay;
                        if (cmd_reg == CMD_STORE) begin
                            load_data = upd_entry;
                        end
                    end
                end
            end
            ST_EVICT: begin
                if (CMP_W'(cnt_reg) >= cap_w && cnt_reg != '0) begin
                    if (!report_reg || out_free) begin
                        shift_en  = 1'b1;
                        cnt_next  = cnt_reg - CNT_W'(1);
                        capc_next = capc_reg + CNTR_W'(1);
                        emit      = report_reg;
                        e_kind    = KIND_CAPACITY;
                    end
                end else begin
                    load_any   = 1'b1;
                    load_idx   = cnt_reg;
                    load_data  = new_entry;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_last     = 1'b1;
                    e_hi       = hi_reg;
                    e_lo       = lo_reg;
                    e_key      = '0;
                    e_pay      = '0;
                    e_time     = '0;
                    state_next = ST_IDLE;
                    case (cmd_reg)
                        CMD_CLEAR: begin
                            cnt_next = '0;
                            e_kind   = KIND_CLEARED;
                            e_hi     = '0;
                            e_lo     = '0;
                        end
                        CMD_STORE: e_kind = KIND_STORED;
                        default: begin
                            if (!found_reg) begin
                                miss_next = miss_reg + CNTR_W'(1);
                                e_kind    = KIND_MISS;
                            end else if (!mkey_reg) begin
                                mism_next = mism_reg + CNTR_W'(1);
                                e_kind    = KIND_MISMATCH;
                            end else begin
                                hit_next = hit_reg + CNTR_W'(1);
                                e_kind   = KIND_HIT;
                                e_pay    = mpay_reg;
                            end
                        end
                    endcase
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            rot_reg   <= '0;
            gone_reg  <= '0;
            found_reg <= 1'b0;
            mkey_reg  <= 1'b0;
            hit_reg   <= '0;
            miss_reg  <= '0;
            mism_reg  <= '0;
            exp_reg   <= '0;
            capc_reg  <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rot_reg   <= rot_next;
            gone_reg  <= gone_next;
            found_reg <= found_next;
            mkey_reg  <= mkey_next;
            hit_reg   <= hit_next;
            miss_reg  <= miss_next;
            mism_reg  <= mism_next;
            exp_reg   <= exp_next;
            capc_reg  <= capc_next;
        end
    end

    // request capture and match payload
    always_ff @(posedge aclk) begin
        mpay_reg <= mpay_next;
        if (s_tvalid && s_tready) begin
            cmd_reg <= cmd_t'(s_tuser);
            hi_reg  <= s_tdata[63:0];
            lo_reg  <= s_tdata[127:64];
            key_reg <= s_tdata[128 +: KEY_WIDTH];
            pay_reg <= s_tdata[255:192];
            now_reg <= s_tdata[303:256];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_kind_reg <= e_kind;
            out_last_reg <= e_last;
            out_hi_reg   <= e_hi;
            out_lo_reg   <= e_lo;
            out_key_reg  <= e_key;
            out_pay_reg  <= e_pay;
            out_time_reg <= e_time;
            out_hit_reg  <= hit_next;
            out_miss_reg <= miss_next;
            out_mism_reg <= mism_next;
            out_exp_reg  <= exp_next;
            out_capc_reg <= capc_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {out_capc_reg, out_exp_reg, out_mism_reg, out_miss_reg, out_hit_reg,
                       out_time_reg, out_pay_reg, out_key_reg, out_lo_reg, out_hi_reg};

    // checks
    `ATRC_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(DEPTH), "entry count above depth")
    `ATRC_ASSERT_IMP(a_no_overwrite, emit, out_free, "result overwritten before taken")
    `ATRC_ASSERT_NXT(a_start_count,
        s_tvalid && s_tready && (s_tuser == CMD_STORE || s_tuser == CMD_FIND),
        state_reg == ST_COUNT, "store or find did not start the age pass")

endmodule

// ===== hdl/atrc_cell.sv =====
// One table entry of the cache chain: loads a new entry or takes its right neighbor.
module atrc_cell #(
    parameter int W = 304
) (
    input  logic         aclk,
    input  logic         shift_en,
    input  logic         load_en,
    input  logic [W-1:0] load_data,
    input  logic [W-1:0] right_data,
    output logic [W-1:0] data_out
);

    logic [W-1:0] data_reg;

    // load wins over the shift so a rotated entry lands at the tail
    always_ff @(posedge aclk) begin
        if (load_en) begin
            data_reg <= load_data;
        end else if (shift_en) begin
            data_reg <= right_data;
        end
    end

    assign data_out = data_reg;

endmodule

// ===== tb/tb_aging_transaction_result_cache.sv =====
// Testbench for the aging transaction result cache: directed table, capacity test, then random requests.
module tb_aging_transaction_result_cache;
    import atrc_pkg::*;

    localparam int NSLOT = 16;
    localparam int QUIET_LIMIT = 20000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] id_hi;
        logic [63:0] id_lo;
        logic [63:0] key;
        logic [63:0] payload;
        logic [47:0] stored_at;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] mismatches;
        logic [31:0] expired;
        logic [31:0] capacity;
        logic        last;
    } record_t;

    typedef struct {
        cmd_t        cmd;
        logic [63:0] id_hi;
        logic [63:0] id_lo;
        logic [63:0] key;
        logic [63:0] payload;
        logic [47:0] now;
        logic        check_kind;
        kind_t       want_kind;
    } request_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [1:0] cfg_addr = '0;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [2:0] m_tuser;
    logic m_tlast;

    aging_transaction_result_cache DUT (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // cache mirror
    int          live;
    logic [63:0] mir_hi [NSLOT];
    logic [63:0] mir_lo [NSLOT];
    logic [63:0] mir_key [NSLOT];
    logic [63:0] mir_pay [NSLOT];
    logic [47:0] mir_time [NSLOT];
    logic [31:0] n_hit, n_miss, n_mismatch, n_expired, n_capacity;
    logic [4:0]  cap_reg;
    logic [31:0] retention_reg;
    logic        report_reg;

    record_t     pending_records[$];
    logic        kind_pinned[$];
    kind_t       pinned_kind[$];
    int          errors = 0;
    int          n_requests = 0;
    int          n_results = 0;
    int          quiet = 0;
    logic        draining = 1'b0;
    int          hold_gap = 0;

    function automatic record_t make_rec(kind_t k, logic [63:0] hi, logic [63:0] lo,
                                         logic [63:0] key, logic [63:0] pay, logic [47:0] t);
        record_t r;
        r = '{k, hi, lo, key, pay, t, n_hit, n_miss, n_mismatch, n_expired, n_capacity, 1'b0};
        return r;
    endfunction

    function automatic logic aged(int i, logic [47:0] now);
        return now >= mir_time[i] && (now - mir_time[i]) > {16'd0, retention_reg};
    endfunction

    function automatic void remove_slot(int idx);
        for (int i = idx; i < live - 1; i++) begin
            mir_hi[i] = mir_hi[i+1]; mir_lo[i] = mir_lo[i+1]; mir_key[i] = mir_key[i+1];
            mir_pay[i] = mir_pay[i+1]; mir_time[i] = mir_time[i+1];
        end
        live--;
    endfunction

    // compute the records one request produces and update the mirror
    function automatic void predict_cache(request_t rq);
        record_t outs[$];
        int pos, gone, cap, i;
        pos = -1;
        gone = 0;
        if (rq.cmd == CMD_NOP) return;
        if (rq.cmd == CMD_CLEAR) begin
            live = 0;
            outs = {outs, make_rec(KIND_CLEARED, '0, '0, '0, '0, '0)};
        end else begin
            for (i = 0; i < live; i++) if (aged(i, rq.now)) gone++;
            n_expired += gone;
            i = 0;
            while (i < live) begin
                if (aged(i, rq.now)) begin
                    if (report_reg)
                        outs = {outs, make_rec(KIND_EXPIRED, mir_hi[i], mir_lo[i], mir_key[i],
                                               mir_pay[i], mir_time[i])};
                    remove_slot(i);
                end else i++;
            end
            for (i = 0; i < live; i++)
                if (pos < 0 && mir_hi[i] == rq.id_hi && mir_lo[i] == rq.id_lo) pos = i;
            if (rq.cmd == CMD_STORE) begin
                if (pos >= 0) begin
                    mir_key[pos] = rq.key;
                    mir_pay[pos] = rq.payload;
                end else begin
                    cap = (cap_reg > NSLOT) ? NSLOT : cap_reg;
                    while (live >= cap && live > 0) begin
                        n_capacity++;
                        if (report_reg)
                            outs = {outs, make_rec(KIND_CAPACITY, mir_hi[0], mir_lo[0],
                                                   mir_key[0], mir_pay[0], mir_time[0])};
                        remove_slot(0);
                    end
                    mir_hi[live] = rq.id_hi; mir_lo[live] = rq.id_lo; mir_key[live] = rq.key;
                    mir_pay[live] = rq.payload; mir_time[live] = rq.now;
                    live++;
                end
                outs = {outs, make_rec(KIND_STORED, rq.id_hi, rq.id_lo, '0, '0, '0)};
            end else if (pos < 0) begin
                n_miss++;
                outs = {outs, make_rec(KIND_MISS, rq.id_hi, rq.id_lo, '0, '0, '0)};
            end else if (mir_key[pos] != rq.key) begin
                n_mismatch++;
                outs = {outs, make_rec(KIND_MISMATCH, rq.id_hi, rq.id_lo, '0, '0, '0)};
            end else begin
                n_hit++;
                outs = {outs, make_rec(KIND_HIT, rq.id_hi, rq.id_lo, '0, mir_pay[pos], '0)};
            end
        end
        outs[outs.size()-1].last = 1'b1;
        foreach (outs[j]) begin
            pending_records = {pending_records, outs[j]};
            // typed-in kind applies to the final record of a table row
            kind_pinned = {kind_pinned, rq.check_kind && j == outs.size() - 1};
            pinned_kind = {pinned_kind, rq.want_kind};
        end
    endfunction

    // config writes mirror the block's register handling
    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_MAX_ENTRIES: cap_reg = (val[4:0] == 0) ? 5'd1 : val[4:0];
            REG_RETENTION:   retention_reg = val;
            REG_REPORT:      report_reg = val[0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_records.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    // valid stays up after acceptance until the next request or an idle point
    task automatic send_request(request_t rq);
        int gap;
        gap = $urandom_range(0, 10);
        if (gap != 0) s_tvalid <= 1'b0;
        repeat (gap) @(posedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= rq.cmd;
        s_tdata <= {rq.now, rq.payload, rq.key, rq.id_lo, rq.id_hi};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_cache(rq);
        n_requests++;
    endtask

    // fully random 64-bit value; rand_request draws ids mostly from a small pool so finds and updates hit
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic request_t rand_request(logic [47:0] now);
        request_t rq;
        int sel;
        sel = $urandom_range(0, 99);
        rq.cmd = sel < 50 ? CMD_STORE : sel < 92 ? CMD_FIND : sel < 96 ? CMD_CLEAR : CMD_NOP;
        if ($urandom_range(0, 9) < 8) begin
            rq.id_hi = {60'h0, 4'($urandom_range(0, 11))};
            rq.id_lo = {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0, 32'($urandom_range(0, 3))};
        end else begin
            rq.id_hi = rand64();
            rq.id_lo = rand64();
        end
        rq.key = $urandom_range(0, 3) == 0 ? rand64() : {62'h0, 2'($urandom_range(0, 1))};
        rq.payload = rand64();
        rq.now = now;
        rq.check_kind = 1'b0;
        rq.want_kind = KIND_STORED;
        return rq;
    endfunction

    // result checker and stall generator
    always @(posedge aclk) begin
        record_t got, want;
        logic pin;
        kind_t pk;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.kind = m_tuser;
                got.last = m_tlast;
                got.stored_at = m_tdata[303:256];
                got.hits = m_tdata[335:304];
                got.misses = m_tdata[367:336];
                got.mismatches = m_tdata[399:368];
                got.expired = m_tdata[431:400];
                got.capacity = m_tdata[463:432];
                got.id_hi = m_tdata[63:0];
                got.id_lo = m_tdata[127:64];
                got.key = m_tdata[191:128];
                got.payload = m_tdata[255:192];
                n_results++;
                if (pending_records.size() == 0) begin
                    $error("unexpected result kind=%0d", m_tuser);
                    errors++;
                end else begin
                    want = pending_records.pop_front();
                    pin = kind_pinned.pop_front();
                    pk = pinned_kind.pop_front();
                    if (pin && got.kind != pk) begin
                        $error("kind (table): expected %0d got %0d", pk, got.kind);
                        errors++;
                    end
                    if (got.kind != want.kind) begin
                        $error("kind: expected %0d got %0d", want.kind, got.kind); errors++;
                    end
                    if (got.id_hi != want.id_hi) begin
                        $error("out_tx_id_hi: expected %h got %h", want.id_hi, got.id_hi); errors++;
                    end
                    if (got.id_lo != want.id_lo) begin
                        $error("out_tx_id_lo: expected %h got %h", want.id_lo, got.id_lo); errors++;
                    end
                    if (got.key != want.key) begin
                        $error("out_key: expected %h got %h", want.key, got.key); errors++;
                    end
                    if (got.payload != want.payload) begin
                        $error("out_payload: expected %h got %h", want.payload, got.payload);
                        errors++;
                    end
                    if (got.stored_at != want.stored_at) begin
                        $error("stored_at: expected %h got %h", want.stored_at, got.stored_at);
                        errors++;
                    end
                    if (got.hits != want.hits) begin
                        $error("hit_count: expected %0d got %0d", want.hits, got.hits); errors++;
                    end
                    if (got.misses != want.misses) begin
                        $error("miss_count: expected %0d got %0d", want.misses, got.misses);
                        errors++;
                    end
                    if (got.mismatches != want.mismatches) begin
                        $error("mismatch_count: expected %0d got %0d", want.mismatches,
                               got.mismatches);
                        errors++;
                    end
                    if (got.expired != want.expired) begin
                        $error("expired_count: expected %0d got %0d", want.expired, got.expired);
                        errors++;
                    end
                    if (got.capacity != want.capacity) begin
                        $error("capacity_count: expected %0d got %0d", want.capacity,
                               got.capacity);
                        errors++;
                    end
                    if (got.last != want.last) begin
                        $error("last: expected %0d got %0d", want.last, got.last); errors++;
                    end
                end
            end
            // ready: after a record, either stays high or drops for a random hold-off; always high while draining
            if (hold_gap > 0) begin
                hold_gap <= hold_gap - 1;
                m_tready <= 1'b0;
            end else if (m_tvalid && m_tready) begin
                if (draining || $urandom_range(0, 3) == 0) begin
                    m_tready <= 1'b1;
                end else begin
                    hold_gap <= $urandom_range(0, 10);
                    m_tready <= 1'b0;
                end
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on handshake inactivity
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("timeout with %0d results outstanding", pending_records.size());
            $display("tb_aging_transaction_result_cache: errors");
            $finish;
        end
    end

    request_t directed_rows[$];
    logic [47:0] clock_ms;

    initial begin
        request_t rq;
        live = 0;
        n_hit = 0; n_miss = 0; n_mismatch = 0; n_expired = 0; n_capacity = 0;
        cap_reg = MAX_ENTRIES_RST;
        retention_reg = RETENTION_RST;
        report_reg = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table: cmd, id, key, payload, now, typed kind
        directed_rows = '{
            '{CMD_FIND,  '0, '0, '0, '0, 48'd0, 1'b1, KIND_MISS},
            '{CMD_STORE, '0, '0, '0, '0, 48'd0, 1'b1, KIND_STORED},
            '{CMD_FIND,  '0, '0, '0, '0, 48'd0, 1'b1, KIND_HIT},
            '{CMD_STORE, '1, '1, '1, '1, 48'd10, 1'b1, KIND_STORED},
            '{CMD_FIND,  '1, '1, '1, '0, 48'd20, 1'b1, KIND_HIT},
            '{CMD_FIND,  '1, '1, 64'h1, '0, 48'd20, 1'b1, KIND_MISMATCH},
            '{CMD_STORE, '1, '1, 64'h5, 64'hA5A5, 48'd30, 1'b1, KIND_STORED},
            '{CMD_FIND,  '1, '1, 64'h5, '0, 48'd40, 1'b0, KIND_HIT},
            '{CMD_NOP,   '1, '1, '1, '1, '1, 1'b0, KIND_HIT},
            '{CMD_FIND,  64'h2, 64'h3, '0, '0, 48'd5, 1'b0, KIND_MISS},
            '{CMD_FIND,  '0, '0, '0, '0, 48'd60000, 1'b1, KIND_HIT},
            '{CMD_FIND,  '0, '0, '0, '0, 48'd60001, 1'b1, KIND_MISS},
            '{CMD_STORE, 64'h7, 64'h7, 64'h7, 64'h7, '1, 1'b1, KIND_STORED},
            '{CMD_FIND,  64'h7, 64'h7, 64'h7, '0, 48'd3, 1'b1, KIND_HIT},
            '{CMD_CLEAR, '1, '1, '1, '1, '1, 1'b1, KIND_CLEARED},
            '{CMD_FIND,  64'h7, 64'h7, 64'h7, '0, 48'd3, 1'b1, KIND_MISS}
        };
        foreach (directed_rows[i]) send_request(directed_rows[i]);

        // capacity 0 acts as 1, evictions reported, short retention
        wait_idle();
        write_reg(REG_MAX_ENTRIES, 32'd0);
        write_reg(REG_REPORT, 32'd1);
        write_reg(REG_RETENTION, 32'd0);
        for (int i = 0; i < 4; i++) begin
            rq = '{CMD_STORE, 64'(i), 64'(i), 64'(i), 64'(i), 48'd100, 1'b0, KIND_STORED};
            send_request(rq);
        end
        rq = '{CMD_FIND, 64'h3, 64'h3, 64'h3, '0, 48'd101, 1'b1, KIND_MISS};
        send_request(rq);

        // random phases through several register settings
        clock_ms = 48'd1000;
        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            case (ph)
                0: begin write_reg(REG_MAX_ENTRIES, 32'd16); write_reg(REG_RETENTION, 32'd50);
                         write_reg(REG_REPORT, 32'd1); end
                1: begin write_reg(REG_MAX_ENTRIES, 32'd31); write_reg(REG_RETENTION, '1);
                         write_reg(REG_REPORT, 32'd0); end
                2: begin write_reg(REG_MAX_ENTRIES, 32'd3); write_reg(REG_RETENTION, 32'd20);
                         write_reg(REG_REPORT, 32'd1); end
                3: begin write_reg(REG_MAX_ENTRIES, 32'd1); write_reg(REG_RETENTION, 32'd0); end
                4: begin write_reg(REG_MAX_ENTRIES, 32'($urandom_range(1, 31)));
                         write_reg(REG_RETENTION, 32'($urandom_range(0, 200))); end
                default: begin write_reg(REG_MAX_ENTRIES, 32'd8);
                         write_reg(REG_RETENTION, 32'd60000); write_reg(REG_REPORT, 32'd1); end
            endcase
            for (int i = 0; i < 60; i++) begin
                // time mostly advances, sometimes steps back or jumps to a random value
                case ($urandom_range(0, 19))
                    0: clock_ms = clock_ms - 48'($urandom_range(0, 100));
                    1: clock_ms = 48'({$urandom, $urandom});
                    default: clock_ms = clock_ms + 48'($urandom_range(0, 15));
                endcase
                send_request(rand_request(clock_ms));
                if (i == 30 && ph == 2) begin
                    s_tvalid <= 1'b0;
                    @(posedge aclk);
                    while (pending_records.size() != 0) @(posedge aclk);
                end
            end
        end

        draining = 1'b1;
        s_tvalid <= 1'b0;
        while (pending_records.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("covered %0d requests and %0d result records over 8 register settings",
                 n_requests, n_results);
        $display("hits %0d misses %0d mismatches %0d aged out %0d capacity evicted %0d",
                 n_hit, n_miss, n_mismatch, n_expired, n_capacity);
        if (errors == 0) begin
            $display("tb_aging_transaction_result_cache: clean");
        end else begin
            $display("tb_aging_transaction_result_cache: errors");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/atrc_pkg.sv
hdl/atrc_cell.sv
hdl/aging_transaction_result_cache.sv
tb/tb_aging_transaction_result_cache.sv
